// ===== rtl/core/tcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // Request kinds carried in the req_type field
    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_kind;

    // Control characters used by put byte
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HIDDEN = 1'd1;

    localparam logic [7:0] TEXT_COLOR_RST = 8'd15;

    typedef struct packed {
        t_req_kind  req_type;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cursor_address;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/tcc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcc_req_if;
    import tcc_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcc_rsp_if;
    import tcc_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a ROWS x COLS screen store of {attribute, character} cells in one
// block RAM plus a cursor, driven by one request item at a time on i_req, with one result
// item per request on o_rsp. A small sequencer drives a shared row*COLS+col address unit
// and the single RAM port pair. When the cursor is hidden, the attribute read-modify-write
// is skipped for set cursor, newline, carriage return and printable bytes; read cell and
// backspace are unchanged. A move past the last row adds a scroll copy, which streams the
// RAM one cell per cycle; clear screen and a scroll of ROWS lines or more do a zero fill
// of all ROWS*COLS cells instead. After reset a clearing pass zeroes the store before the
// first item is accepted; configuration writes are taken at any time, but only while idle
// they are meaningful. A finished result waits in an output register while the next item
// is accepted; the block is ready for that item as the result is registered.
module text_console_cursor_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tcc_req_if.sink                             i_req,
    tcc_rsp_if.source                           o_rsp
);
    import tcc_pkg::*;

    localparam int N     = ROWS * COLS;
    localparam int IW    = $clog2(N);
    localparam int PTRW  = IW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int MRW   = ($clog2(ROWS + 1) > 8) ? $clog2(ROWS + 1) : 8;
    localparam logic [15:0] HID_ADDR = 16'((COLS * COLS + ROWS) % 65536);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW_ADDR,
        S_DRAW,
        S_MOVE,
        S_SCR_OFS,
        S_SCR_PRIME,
        S_SCROLL,
        S_PAINT_ADDR,
        S_PAINT_RD,
        S_PAINT_WR,
        S_RD_ADDR,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } t_state;

    t_state           r_state;
    logic             r_init;
    logic [7:0]       r_color;
    logic             r_hidden;
    logic [RW-1:0]    r_cur_row;
    logic [CW-1:0]    r_cur_col;
    logic [MRW-1:0]   r_mv_row;
    logic [CW-1:0]    r_mv_col;
    logic [RW-1:0]    r_len;
    logic [RW-1:0]    r_tgt_row;
    logic [CW-1:0]    r_tgt_col;
    logic [7:0]       r_char;
    logic             r_draw_bs;
    logic [IW-1:0]    r_addr;
    logic [IW-1:0]    r_wp;
    logic [PTRW-1:0]  r_rp;
    logic             r_rd_ok;
    logic             r_status;
    logic [15:0]      r_cell;
    logic             r_out_valid;
    t_rsp             r_rsp;

    logic [RW-1:0]    w_mul_a;
    logic [CW-1:0]    w_mul_b;
    logic [IW-1:0]    w_mul;
    logic [MRW-1:0]   w_len;
    logic             w_accept;
    logic             w_ram_we;
    logic [IW-1:0]    w_ram_waddr;
    logic [15:0]      w_ram_wdata;
    logic [IW-1:0]    w_ram_raddr;
    logic [15:0]      w_ram_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Shared address unit: row * COLS + col
    always_comb begin
        w_mul_a = r_cur_row;
        w_mul_b = r_cur_col;
        case (r_state)
            S_RD_ADDR: begin
                w_mul_a = r_tgt_row;
                w_mul_b = r_tgt_col;
            end
            S_SCR_OFS: begin
                w_mul_a = r_len;
                w_mul_b = '0;
            end
            default: begin
                w_mul_a = r_cur_row;
                w_mul_b = r_cur_col;
            end
        endcase
        w_mul = IW'(w_mul_a) * IW'(COLS) + IW'(w_mul_b);
    end

    // Lines to scroll when the move target is past the last row
    assign w_len = r_mv_row - MRW'(ROWS - 1);

    // Steer the RAM ports
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = {r_color, r_char};
        w_ram_raddr = r_addr;
        case (r_state)
            S_SCR_PRIME: begin
                w_ram_raddr = r_rp[IW-1:0];
            end
            S_SCROLL: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_wp;
                w_ram_wdata = r_rd_ok ? w_ram_rdata : 16'h0000;
                w_ram_raddr = r_rp[IW-1:0];
            end
            S_DRAW: begin
                w_ram_we = 1'b1;
            end
            S_PAINT_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = {r_color, w_ram_rdata[7:0]};
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    tcc_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer, cursor, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCROLL;
            r_init      <= 1'b1;
            r_color     <= TEXT_COLOR_RST;
            r_hidden    <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_wp        <= '0;
            r_rp        <= PTRW'(N);
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEXT_COLOR:    r_color  <= i_cfg_wdata;
                    CFG_CURSOR_HIDDEN: r_hidden <= i_cfg_wdata[0];
                    default:           r_color  <= r_color;
                endcase
            end

            // Drop the result once taken, unless the finishing step refills it
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= 1'b0;
                        r_cell   <= 16'h0000;
                        case (i_req.data.req_type)
                            REQ_PUT: begin
                                case (i_req.data.char_code)
                                    CH_NL: begin
                                        r_mv_row <= MRW'(r_cur_row) + MRW'(1);
                                        r_mv_col <= '0;
                                        r_state  <= S_MOVE;
                                    end
                                    CH_CR: begin
                                        r_mv_row <= MRW'(r_cur_row);
                                        r_mv_col <= '0;
                                        r_state  <= S_MOVE;
                                    end
                                    CH_BS: begin
                                        // Step back, wrapping to the previous line
                                        if (r_cur_col == '0) begin
                                            if (r_cur_row != '0) begin
                                                r_cur_row <= r_cur_row - RW'(1);
                                                r_cur_col <= CW'(COLS - 1);
                                            end
                                        end else begin
                                            r_cur_col <= r_cur_col - CW'(1);
                                        end
                                        r_char    <= CH_NUL;
                                        r_draw_bs <= 1'b1;
                                        r_state   <= S_DRAW_ADDR;
                                    end
                                    default: begin
                                        r_char    <= i_req.data.char_code;
                                        r_draw_bs <= 1'b0;
                                        r_state   <= S_DRAW_ADDR;
                                    end
                                endcase
                            end
                            REQ_SET: begin
                                if (9'(i_req.data.target_col) < 9'(COLS)) begin
                                    r_mv_row <= MRW'(i_req.data.target_row);
                                    r_mv_col <= CW'(i_req.data.target_col);
                                    r_state  <= S_MOVE;
                                end else begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end
                            end
                            REQ_READ: begin
                                if ((9'(i_req.data.target_row) < 9'(ROWS)) &&
                                    (9'(i_req.data.target_col) < 9'(COLS))) begin
                                    r_tgt_row <= RW'(i_req.data.target_row);
                                    r_tgt_col <= CW'(i_req.data.target_col);
                                    r_state   <= S_RD_ADDR;
                                end else begin
                                    r_status <= 1'b1;
                                    r_state  <= S_DONE;
                                end
                            end
                            REQ_CLEAR: begin
                                // Home the cursor, zero fill the whole store, then paint
                                r_cur_row <= '0;
                                r_cur_col <= '0;
                                r_wp      <= '0;
                                r_rp      <= PTRW'(N);
                                r_rd_ok   <= 1'b0;
                                r_state   <= S_SCROLL;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_DRAW_ADDR: begin
                    r_addr  <= w_mul;
                    r_state <= S_DRAW;
                end

                S_DRAW: begin
                    // Backspace ends here; a drawn byte advances the cursor
                    if (r_draw_bs) begin
                        r_state <= S_DONE;
                    end else begin
                        if (r_cur_col == CW'(COLS - 1)) begin
                            r_mv_row <= MRW'(r_cur_row) + MRW'(1);
                            r_mv_col <= '0;
                        end else begin
                            r_mv_row <= MRW'(r_cur_row);
                            r_mv_col <= r_cur_col + CW'(1);
                        end
                        r_state <= S_MOVE;
                    end
                end

                S_MOVE: begin
                    if (r_mv_row > MRW'(ROWS - 1)) begin
                        if (w_len >= MRW'(ROWS)) begin
                            r_cur_row <= '0;
                            r_cur_col <= '0;
                            r_wp      <= '0;
                            r_rp      <= PTRW'(N);
                            r_rd_ok   <= 1'b0;
                            r_state   <= S_SCROLL;
                        end else begin
                            r_cur_row <= RW'(ROWS - 1);
                            r_cur_col <= r_mv_col;
                            r_len     <= RW'(w_len);
                            r_state   <= S_SCR_OFS;
                        end
                    end else begin
                        r_cur_row <= RW'(r_mv_row);
                        r_cur_col <= r_mv_col;
                        r_state   <= S_PAINT_ADDR;
                    end
                end

                S_SCR_OFS: begin
                    r_rp    <= PTRW'(w_mul);
                    r_wp    <= '0;
                    r_state <= S_SCR_PRIME;
                end

                S_SCR_PRIME: begin
                    // First source read in flight
                    r_rd_ok <= (r_rp < PTRW'(N));
                    r_rp    <= r_rp + PTRW'(1);
                    r_state <= S_SCROLL;
                end

                S_SCROLL: begin
                    // Write one cell, read the next source cell
                    r_rd_ok <= (r_rp < PTRW'(N));
                    if (r_rp < PTRW'(N)) begin
                        r_rp <= r_rp + PTRW'(1);
                    end
                    if (r_wp == IW'(N - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_PAINT_ADDR;
                    end else begin
                        r_wp <= r_wp + IW'(1);
                    end
                end

                S_PAINT_ADDR: begin
                    r_addr  <= w_mul;
                    r_state <= r_hidden ? S_DONE : S_PAINT_RD;
                end

                S_PAINT_RD: begin
                    r_state <= S_PAINT_WR;
                end

                S_PAINT_WR: begin
                    r_state <= S_DONE;
                end

                S_RD_ADDR: begin
                    r_addr  <= w_mul;
                    r_state <= S_RD_ISSUE;
                end

                S_RD_ISSUE: begin
                    r_state <= S_RD_DATA;
                end

                S_RD_DATA: begin
                    r_cell  <= w_ram_rdata;
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // Hold until the result slot is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid               <= 1'b1;
                        r_rsp.status              <= r_status;
                        r_rsp.cell_char           <= r_cell[7:0];
                        r_rsp.cell_color          <= r_cell[15:8];
                        r_rsp.cursor_row          <= 5'(r_cur_row);
                        r_rsp.cursor_col          <= 7'(r_cur_col);
                        r_rsp.cursor_address      <= r_hidden ? HID_ADDR : 16'(w_mul);
                        r_state                   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Cursor stays on screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur_row} < (RW + 1)'(ROWS))
        else $error("cursor row off screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur_col} < (CW + 1)'(COLS))
        else $error("cursor column off screen");

    // Scroll copy never reads a cell already overwritten
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_rp > PTRW'(r_wp)))
        else $error("scroll read pointer behind write pointer");

    // A new result appears only from the finishing step
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside finishing step");
`endif

endmodule

`default_nettype wire
